### sv/matrix_3x3_inverse_assert.svh
// Assertion macros for the matrix_3x3_inverse block.
// Included by modules that carry concurrent checks.
`ifndef MATRIX_3X3_INVERSE_ASSERT_SVH
`define MATRIX_3X3_INVERSE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define M3I_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define M3I_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define M3I_ASSERT_IMP(lbl, clk, rstn, a, c)
`define M3I_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

### sv/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse.
// No dependencies.
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;          // product of two entries
  localparam int CW = PW + 1;          // cofactor
  localparam int TW = CW + DW + 2;     // determinant
  localparam int NW = CW + 2 * FB;     // shifted numerator magnitude
  localparam int QW = NW;              // quotient width
  localparam int FL = 4;               // front pipeline stages
  localparam int QD = 8;               // front to back queue depth
  localparam int QAW = 3;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [TW-1:0] det_t;

  typedef struct packed {
    word_t [8:0] a;
    cof_t  [8:0] c;       // c[i*3+j] = C(i,j)
    det_t        det;
  } job_t;

  typedef struct packed {
    word_t [8:0] b;
    word_t       det_value;
    logic        singular;
    logic        overflow;
  } res_t;
endpackage

### sv/m3i_front.sv
// Front: four registered stages form products, cofactors and determinant terms.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  m3i_pkg::word_t [8:0] in_a,
  input  logic               stall,
  output logic               out_vld,
  output m3i_pkg::job_t      out_job
);
  logic [m3i_pkg::FL-1:0] vld_r, vld_nxt;
  m3i_pkg::word_t [8:0] a1_r, a2_r, a3_r, a4_r;
  logic signed [m3i_pkg::PW-1:0] p_r [18];
  m3i_pkg::cof_t [8:0] c_r, c3_r, c4_r;
  m3i_pkg::cof_t ph_r [3];   // entry times upper cofactor half
  m3i_pkg::cof_t pl_r [3];   // entry times lower cofactor half
  m3i_pkg::det_t d_r [3];
  m3i_pkg::det_t det_sum;

  always_comb begin
    vld_nxt = vld_r;
    if (!stall) vld_nxt = {vld_r[m3i_pkg::FL-2:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      a1_r <= in_a;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[2*(i*3+j)]   <= in_a[((i+1)%3)*3+(j+1)%3] * in_a[((i+2)%3)*3+(j+2)%3];
          p_r[2*(i*3+j)+1] <= in_a[((i+2)%3)*3+(j+1)%3] * in_a[((i+1)%3)*3+(j+2)%3];
        end
      end
      a2_r <= a1_r;
      for (int k = 0; k < 9; k++)
        c_r[k] <= m3i_pkg::CW'(p_r[2*k]) - m3i_pkg::CW'(p_r[2*k+1]);
      a3_r <= a2_r;
      c3_r <= c_r;
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= a2_r[j] * $signed(c_r[j][m3i_pkg::CW-1:m3i_pkg::DW]);
        pl_r[j] <= a2_r[j] * $signed({1'b0, c_r[j][m3i_pkg::DW-1:0]});
      end
      a4_r <= a3_r;
      c4_r <= c3_r;
      for (int j = 0; j < 3; j++)
        d_r[j] <= (m3i_pkg::TW'(ph_r[j]) <<< m3i_pkg::DW) + m3i_pkg::TW'(pl_r[j]);
    end
  end

  always_comb begin
    det_sum = d_r[0] + d_r[1] + d_r[2];
    out_vld = vld_r[m3i_pkg::FL-1];
    out_job.a = a4_r;
    out_job.c = c4_r;
    out_job.det = det_sum;
  end
endmodule

### sv/m3i_queue.sv
// Short queue between front and back.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
`include "matrix_3x3_inverse_assert.svh"
module m3i_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  m3i_pkg::job_t wdata,
  input  logic          rd,
  output m3i_pkg::job_t rdata,
  output logic          nonempty,
  output logic [m3i_pkg::QAW:0] count
);
  m3i_pkg::job_t mem [m3i_pkg::QD];
  m3i_pkg::job_t rd_r;
  logic [m3i_pkg::QAW-1:0] wp_r, rp_r, rp_nxt;
  logic [m3i_pkg::QAW:0] cnt_r;

  assign rp_nxt = rd ? rp_r + 1'b1 : rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_nxt;
      cnt_r <= cnt_r + (m3i_pkg::QAW+1)'(wr) - (m3i_pkg::QAW+1)'(rd);
    end
  end

  // head item is held in rd_r; a write to the head slot goes straight through
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
    if (wr && wp_r == rp_nxt) rd_r <= wdata;
    else rd_r <= mem[rp_nxt];
  end

  assign rdata = rd_r;
  assign nonempty = cnt_r != '0;
  assign count = cnt_r;

  `M3I_ASSERT_IMP(a_no_overrun, clk, rst_n, wr && !rd, cnt_r < (m3i_pkg::QAW+1)'(m3i_pkg::QD))
  `M3I_ASSERT_IMP(a_no_underrun, clk, rst_n, rd, cnt_r != '0)
  `M3I_ASSERT_NXT(a_count_up, clk, rst_n, wr && !rd, cnt_r == $past(cnt_r) + 1'b1)
endmodule

### sv/m3i_back.sv
// Back: pipelined restoring dividers, one quotient bit per stage, then saturation.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  m3i_pkg::job_t in_job,
  input  logic          stall,
  output logic          out_vld,
  output m3i_pkg::res_t out_res
);
  localparam int NS = m3i_pkg::QW;
  localparam int RW = m3i_pkg::TW;

  typedef struct packed {
    logic [8:0][m3i_pkg::NW-1:0] num;
    logic [8:0][RW-1:0]          rem;
    logic [8:0]                  neg;
    logic [RW-1:0]               dmag;
    m3i_pkg::word_t [8:0]        a;
    m3i_pkg::det_t               det;
  } st_t;

  st_t  s_r [NS+1];
  logic [NS:0] v_r;
  st_t  s0;
  m3i_pkg::res_t res_r;
  logic vo_r;

  always_comb begin
    s0.a = in_job.a;
    s0.det = in_job.det;
    s0.dmag = in_job.det[RW-1] ? RW'(-in_job.det) : RW'(in_job.det);
    for (int k = 0; k < 9; k++) begin
      s0.rem[k] = '0;
      // b[i][j] = C(j,i)/D
      s0.neg[k] = in_job.c[(k%3)*3+k/3][m3i_pkg::CW-1] ^ in_job.det[RW-1];
      s0.num[k] = {(in_job.c[(k%3)*3+k/3][m3i_pkg::CW-1] ?
                    -in_job.c[(k%3)*3+k/3] : in_job.c[(k%3)*3+k/3]),
                   {(2*m3i_pkg::FB){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (!stall) v_r <= {v_r[NS-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    st_t nx;
    logic [RW:0] t;
    if (!stall) begin
      s_r[0] <= s0;
      for (int s = 0; s < NS; s++) begin
        nx = s_r[s];
        for (int k = 0; k < 9; k++) begin
          t = {s_r[s].rem[k], s_r[s].num[k][m3i_pkg::NW-1]};
          if (t >= {1'b0, s_r[s].dmag}) begin
            nx.rem[k] = RW'(t - {1'b0, s_r[s].dmag});
            nx.num[k] = {s_r[s].num[k][m3i_pkg::NW-2:0], 1'b1};
          end else begin
            nx.rem[k] = RW'(t);
            nx.num[k] = {s_r[s].num[k][m3i_pkg::NW-2:0], 1'b0};
          end
        end
        s_r[s+1] <= nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (!stall) vo_r <= v_r[NS];
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      logic ovf;
      logic [m3i_pkg::NW-1:0] q;
      logic [RW-1:0] dm;
      ovf = 1'b0;
      q = '0;
      dm = '0;
      if (s_r[NS].det == '0) begin
        res_r.b <= s_r[NS].a;
        res_r.det_value <= '0;
        res_r.singular <= 1'b1;
        res_r.overflow <= 1'b0;
      end else begin
        for (int k = 0; k < 9; k++) begin
          q = s_r[NS].num[k];
          if (s_r[NS].neg[k] && q != '0) begin
            if (q > m3i_pkg::NW'(33'h080000000)) begin
              ovf = 1'b1; res_r.b[k] <= 32'sh80000000;
            end else res_r.b[k] <= m3i_pkg::DW'(-q);
          end else begin
            if (q > m3i_pkg::NW'(33'h07fffffff)) begin
              ovf = 1'b1; res_r.b[k] <= 32'sh7fffffff;
            end else res_r.b[k] <= m3i_pkg::DW'(q);
          end
        end
        dm = s_r[NS].dmag >> (2 * m3i_pkg::FB);
        if (s_r[NS].det[RW-1] && dm != '0) begin
          if (dm > RW'(33'h080000000)) begin
            ovf = 1'b1; res_r.det_value <= 32'sh80000000;
          end else res_r.det_value <= m3i_pkg::DW'(-dm);
        end else begin
          if (dm > RW'(33'h07fffffff)) begin
            ovf = 1'b1; res_r.det_value <= 32'sh7fffffff;
          end else res_r.det_value <= m3i_pkg::DW'(dm);
        end
        res_r.singular <= 1'b0;
        res_r.overflow <= ovf;
      end
    end
  end

  assign out_vld = vo_r;
  assign out_res = res_r;
endmodule

### sv/m3i_outq.sv
// Result queue that presents items on the output ports.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  m3i_pkg::res_t wdata,
  input  logic          rd,
  output m3i_pkg::res_t rdata,
  output logic          empty,
  output logic          afull
);
  m3i_pkg::res_t mem [4];
  m3i_pkg::res_t rd_r;
  logic [1:0] wp_r, rp_r, rp_nxt;
  logic [2:0] cnt_r;

  assign rp_nxt = rd ? rp_r + 1'b1 : rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_nxt;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  // head item is held in rd_r; a write to the head slot goes straight through
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
    if (wr && wp_r == rp_nxt) rd_r <= wdata;
    else rd_r <= mem[rp_nxt];
  end

  assign rdata = rd_r;
  assign empty = cnt_r == '0;
  assign afull = cnt_r >= 3'd3;
endmodule

### sv/matrix_3x3_inverse.sv
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// Accepts one item per cycle while full is low; the back registers its input first.
// Stages: 4 front multiply, 1 queue, 97 restoring divide, 1 saturate, 1 result queue.
// Back stalls while the result queue holds 3 or more; full rises at 4 queued jobs.
// Synchronous active-low reset empties all queues and pipelines.
`timescale 1ns / 1ps
`include "matrix_3x3_inverse_assert.svh"
module matrix_3x3_inverse (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  logic signed [31:0] in_a00, in_a01, in_a02, in_a10, in_a11, in_a12,
  input  logic signed [31:0] in_a20, in_a21, in_a22,
  output logic empty,
  input  logic pop,
  output logic signed [31:0] out_b00, out_b01, out_b02, out_b10, out_b11, out_b12,
  output logic signed [31:0] out_b20, out_b21, out_b22, out_det_value,
  output logic out_singular,
  output logic out_overflow
);
  m3i_pkg::word_t [8:0] a;
  logic f_vld, f_stall, q_rd, q_ne, b_vld, b_stall, o_afull;
  logic [m3i_pkg::QAW:0] q_cnt;
  m3i_pkg::job_t f_job, q_job;
  m3i_pkg::res_t b_res, o_res;

  assign a = {in_a22, in_a21, in_a20, in_a12, in_a11, in_a10, in_a02, in_a01, in_a00};
  // front keeps up to FL items in flight; reserve queue room for them
  assign f_stall = 1'b0;
  assign full = q_cnt >= (m3i_pkg::QAW+1)'(m3i_pkg::QD - m3i_pkg::FL);
  assign b_stall = o_afull;
  assign q_rd = q_ne && !b_stall;

  m3i_front u_front (.clk, .rst_n, .in_vld(push && !full), .in_a(a), .stall(f_stall),
    .out_vld(f_vld), .out_job(f_job));

  m3i_queue u_q (.clk, .rst_n, .wr(f_vld), .wdata(f_job), .rd(q_rd), .rdata(q_job),
    .nonempty(q_ne), .count(q_cnt));

  m3i_back u_back (.clk, .rst_n, .in_vld(q_rd), .in_job(q_job), .stall(b_stall),
    .out_vld(b_vld), .out_res(b_res));

  m3i_outq u_oq (.clk, .rst_n, .wr(b_vld && !b_stall), .wdata(b_res),
    .rd(pop && !empty), .rdata(o_res), .empty(empty), .afull(o_afull));

  assign {out_b22, out_b21, out_b20, out_b12, out_b11, out_b10, out_b02, out_b01,
          out_b00} = o_res.b;
  assign out_det_value = o_res.det_value;
  assign out_singular = o_res.singular;
  assign out_overflow = o_res.overflow;

  `M3I_ASSERT_IMP(a_sing_no_ovf, clk, rst_n, !empty && out_singular, !out_overflow)
  `M3I_ASSERT_IMP(a_sing_det0, clk, rst_n, !empty && out_singular, out_det_value == '0)
  `M3I_ASSERT_IMP(a_back_room, clk, rst_n, b_vld && b_stall, !u_oq.empty)
endmodule
